// ===== design/esd_pkg.sv =====
// shared types for the escape sequence decoder
package esd_pkg;

  // decoder mode between characters
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX1  = 2'd2,
    MODE_HEX2  = 2'd3
  } mode_t;

  // one decoded result item
  typedef struct packed {
    logic [7:0] byte_val;
    logic       truncated;
    logic       last;
  } result_t;

  // outcome of decoding one character
  typedef struct packed {
    logic       emit;
    result_t    res;
    mode_t      mode_nxt;
    logic [3:0] nibble_nxt;
  } step_t;

endpackage

// ===== design/esd_decode.sv =====
// combinational decode of one character against the current mode
module esd_decode (
  input  logic [7:0]     ch,
  input  logic           last,
  input  esd_pkg::mode_t mode,
  input  logic [3:0]     nibble,
  output esd_pkg::step_t step
);
  import esd_pkg::*;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] BYTE_NUL     = 8'h00;
  localparam logic [7:0] BYTE_LF      = 8'h0A;
  localparam logic [7:0] BYTE_CR      = 8'h0D;
  localparam logic [7:0] BYTE_TAB     = 8'h09;

  // hex digit value, anything else counts as zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h37;
    return d[3:0];
  endfunction

  logic       trunc;
  logic [3:0] dig;

  assign dig = hex_value(ch);

  // mode update and result selection
  always_comb begin
    trunc           = 1'b0;
    step.emit       = 1'b0;
    step.res.byte_val  = ch;
    step.res.truncated = 1'b0;
    step.res.last      = last;
    step.mode_nxt   = mode;
    step.nibble_nxt = nibble;
    unique case (mode)
      MODE_PLAIN: begin
        if (ch != CH_BACKSLASH) step.emit = 1'b1;
        else if (last) trunc = 1'b1;
        else step.mode_nxt = MODE_ESC;
      end
      MODE_ESC: begin
        step.emit     = 1'b1;
        step.mode_nxt = MODE_PLAIN;
        case (ch)
          CH_ZERO: step.res.byte_val = BYTE_NUL;
          CH_N:    step.res.byte_val = BYTE_LF;
          CH_R:    step.res.byte_val = BYTE_CR;
          CH_T:    step.res.byte_val = BYTE_TAB;
          CH_X: begin
            step.emit = 1'b0;
            if (last) trunc = 1'b1;
            else begin
              step.nibble_nxt = 4'h0;
              step.mode_nxt   = MODE_HEX1;
            end
          end
          default: step.res.byte_val = ch;
        endcase
      end
      MODE_HEX1: begin
        if (last) trunc = 1'b1;
        else begin
          step.nibble_nxt = dig;
          step.mode_nxt   = MODE_HEX2;
        end
      end
      MODE_HEX2: begin
        step.emit         = 1'b1;
        step.res.byte_val = {nibble, dig};
        step.mode_nxt     = MODE_PLAIN;
        step.nibble_nxt   = 4'h0;
      end
    endcase
    // string ended inside an escape
    if (trunc) begin
      step.emit          = 1'b1;
      step.res.byte_val  = BYTE_NUL;
      step.res.truncated = 1'b1;
      step.res.last      = 1'b1;
      step.mode_nxt      = MODE_PLAIN;
      step.nibble_nxt    = 4'h0;
    end
  end

endmodule

// ===== design/esd_out_stage.sv =====
// result register with valid/ready toward the receiver
module esd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  esd_pkg::result_t load_res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output esd_pkg::result_t res
);
  import esd_pkg::*;

  logic    valid_r;
  result_t res_r;

  // slot frees up when empty or being taken this cycle
  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res       = res_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (load) valid_r <= 1'b1;
    else if (out_ready) valid_r <= 1'b0;
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) res_r <= load_res;
  end

endmodule

// ===== design/escape_sequence_decoder_unit.sv =====
// top level of the escape sequence decoder
// Usage:
//   in channel (in_valid/in_ready) carries one string character per item
//   in in_ch, with in_last set on the final character of the string.
//   out channel (out_valid/out_ready) carries decoded bytes: out_byte,
//   out_truncated when the string ended inside an escape (byte is zero),
//   and out_last on the final byte of the string.
//   A character either yields one byte or none (backslash, x and the first
//   hex digit of an escape yield nothing until the escape completes).
// Timing:
//   a character is held in the input register and decoded there; its
//   byte then enters the result register, whose flag drives out_valid
//   toward the receiver.
//   One character is taken every cycle unless a byte is stalled; the rate
//   is set by the single mode register that the decode updates once per item.
// Reset: synchronous active-low rst_n empties both registers and returns
//   the decoder to plain text.
// Stall: while out_ready is low and the result register is full, an item
//   that yields a byte waits in the input register and in_ready drops;
//   items that yield no byte still pass through.
module escape_sequence_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_truncated,
  output logic       out_last
);
  import esd_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_last_r;
  mode_t      mode_r;
  logic [3:0] nibble_r;
  step_t      step;
  logic       free;
  logic       advance;
  result_t    res;

  // decode the held character
  esd_decode u_decode (
    .ch     (s1_ch_r),
    .last   (s1_last_r),
    .mode   (mode_r),
    .nibble (nibble_r),
    .step   (step)
  );

  // held item moves on unless its byte finds the result slot taken
  assign advance  = s1_valid_r && (!step.emit || free);
  assign in_ready = !s1_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (in_ready) s1_valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
  end

  // decoder state advances with each consumed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_PLAIN;
      nibble_r <= 4'h0;
    end else if (advance) begin
      mode_r   <= step.mode_nxt;
      nibble_r <= step.nibble_nxt;
    end
  end

  // result register
  esd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && step.emit),
    .load_res  (step.res),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_byte      = res.byte_val;
  assign out_truncated = res.truncated;
  assign out_last      = res.last;

`ifndef SYNTHESIS
  // a truncated result is a zero byte that closes the string
  a_trunc_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_byte == 8'h00 && out_last)
    else $error("truncated result not a closing zero byte");

  // end of string always returns to plain text
  a_last_resets_mode: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_last_r |=> mode_r == MODE_PLAIN)
    else $error("mode not plain after end of string");

  // stored nibble only meaningful while waiting for the second digit
  a_nibble_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_HEX2 |-> nibble_r == 4'h0)
    else $error("stale high nibble");

  // an empty input register always takes an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled while empty");
`endif

endmodule

// ===== dv/tb_escape_sequence_decoder_unit.sv =====
// testbench for the escape sequence decoder unit: directed and random strings
`timescale 1ns / 100ps

module tb_escape_sequence_decoder_unit;
  import esd_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 9;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_ITEMS  = 250;

  // characters with a meaning to the decoder
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DIGIT_0   = 8'h30;
  localparam logic [7:0] CH_DIGIT_9   = 8'h39;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_F   = 8'h46;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_X   = 8'h78;

  // decoded values of the named escapes
  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_ch = 8'h41;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_truncated;
  logic       out_last;

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int fail_count   = 0;
  int stall_cycles = 0;

  // decoder state as the testbench sees it
  mode_t      esc_mode = MODE_PLAIN;
  logic [3:0] hex_high = 4'd0;

  result_t expected_bytes[$];

  escape_sequence_decoder_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ch        (in_ch),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_truncated(out_truncated),
    .out_last     (out_last)
  );

  // clock
  always #(HALF_PERIOD) clk = ~clk;

  // value of a hex digit, zero for anything else
  function automatic logic [3:0] hex_digit_value(input logic [7:0] c);
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return 4'(c - CH_DIGIT_0);
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return 4'(c - CH_LOWER_A + 8'd10);
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return 4'(c - CH_UPPER_A + 8'd10);
    return 4'd0;
  endfunction

  // advance the decoder by one character, returns 1 when a byte comes out
  function automatic logic decode_char(input logic [7:0] c, input logic lst,
                                       output result_t r);
    r = '0;
    r.last = lst;
    case (esc_mode)
      MODE_PLAIN: begin
        if (c != CH_BACKSLASH) begin
          r.byte_val = c;
          return 1'b1;
        end
        if (lst) begin
          r.truncated = 1'b1;
          return 1'b1;
        end
        esc_mode = MODE_ESC;
        return 1'b0;
      end
      MODE_ESC: begin
        if (c == CH_LOWER_X) begin
          if (lst) begin
            esc_mode = MODE_PLAIN;
            hex_high = 4'd0;
            r.truncated = 1'b1;
            return 1'b1;
          end
          hex_high = 4'd0;
          esc_mode = MODE_HEX1;
          return 1'b0;
        end
        case (c)
          CH_DIGIT_0: r.byte_val = BYTE_NUL;
          CH_LOWER_N: r.byte_val = BYTE_LF;
          CH_LOWER_R: r.byte_val = BYTE_CR;
          CH_LOWER_T: r.byte_val = BYTE_TAB;
          default:    r.byte_val = c;
        endcase
        esc_mode = MODE_PLAIN;
        return 1'b1;
      end
      MODE_HEX1: begin
        if (lst) begin
          esc_mode = MODE_PLAIN;
          hex_high = 4'd0;
          r.truncated = 1'b1;
          return 1'b1;
        end
        hex_high = hex_digit_value(c);
        esc_mode = MODE_HEX2;
        return 1'b0;
      end
      default: begin
        r.byte_val = {hex_high, hex_digit_value(c)};
        esc_mode = MODE_PLAIN;
        hex_high = 4'd0;
        return 1'b1;
      end
    endcase
  endfunction

  // send one character, with random idle cycles ahead of it
  task automatic send_char(input logic [7:0] c, input logic lst);
    result_t r;
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_ch    = c;
    in_last  = lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (decode_char(c, lst, r)) expected_bytes.push_back(r);
  endtask

  // send a literal string, optionally flagging its final character
  task automatic send_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], last_at_end && (i == s.len() - 1));
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_for_bytes();
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= out_idle_pct);
  end

  task automatic report_mismatch(input string what, input result_t want,
                                 input result_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s: expected byte %02h trunc %0b last %0b, got byte %02h trunc %0b last %0b",
               $time, what, want.byte_val, want.truncated, want.last,
               got.byte_val, got.truncated, got.last);
  endtask

  // compare each output item with the oldest expected byte
  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.byte_val  = out_byte;
      got.truncated = out_truncated;
      got.last      = out_last;
      if (expected_bytes.size() == 0) begin
        report_mismatch("byte with none expected", '0, got);
      end else begin
        want = expected_bytes.pop_front();
        if (got.byte_val != want.byte_val || got.truncated != want.truncated ||
            got.last != want.last)
          report_mismatch("wrong byte", want, got);
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_escape_sequence_decoder_unit: FAIL");
      $finish;
    end
  end

  // plain characters at the extremes of the range
  task automatic test_plain_chars();
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b1);
  endtask

  // the named escapes and an escaped backslash
  task automatic test_named_escapes();
    send_text("\\0\\n\\r\\t\\\\", 1'b1);
  endtask

  // hex escapes with both digit cases, a non-hex digit and last on the second digit
  task automatic test_hex_escapes();
    send_text("\\x4a", 1'b0);
    send_text("\\xFz", 1'b1);
  endtask

  // strings that end inside an escape
  task automatic test_open_escape_at_end();
    send_text("\\", 1'b1);
    send_text("\\x", 1'b1);
    send_text("\\x7", 1'b1);
  endtask

  // pause mid-escape until the output is empty, then finish the escape
  task automatic test_drain_pause();
    send_text("ab\\x5", 1'b0);
    idle_input();
    wait_for_bytes();
    send_text("0E", 1'b1);
  endtask

  function automatic logic [7:0] random_hex_char();
    case ($urandom_range(2))
      0:       return CH_DIGIT_0 + 8'($urandom_range(9));
      1:       return CH_LOWER_A + 8'($urandom_range(5));
      default: return CH_UPPER_A + 8'($urandom_range(5));
    endcase
  endfunction

  function automatic logic [7:0] random_plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(255, 1));
    if (c == CH_BACKSLASH) c = CH_UPPER_A;
    return c;
  endfunction

  // random strings: mostly well-formed escapes, some cut short, some noise
  task automatic test_random_strings(input int item_count);
    logic [7:0] chars[$];
    int sent;
    int len;
    int drop;
    sent = 0;
    while (sent < item_count) begin
      chars.delete();
      if ($urandom_range(4) == 0) begin
        // noise with many backslashes
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++)
          chars.push_back(($urandom_range(2) == 0) ? CH_BACKSLASH
                                                    : 8'($urandom_range(255, 1)));
      end else begin
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(9))
            0, 1, 2, 3: chars.push_back(random_plain_char());
            4: begin
              chars.push_back(CH_BACKSLASH);
              case ($urandom_range(3))
                0:       chars.push_back(CH_DIGIT_0);
                1:       chars.push_back(CH_LOWER_N);
                2:       chars.push_back(CH_LOWER_R);
                default: chars.push_back(CH_LOWER_T);
              endcase
            end
            5: begin
              chars.push_back(CH_BACKSLASH);
              chars.push_back(8'($urandom_range(255, 1)));
            end
            6, 7: begin
              chars.push_back(CH_BACKSLASH);
              chars.push_back(CH_LOWER_X);
              chars.push_back(random_hex_char());
              chars.push_back(random_hex_char());
            end
            8: begin
              chars.push_back(CH_BACKSLASH);
              chars.push_back(CH_LOWER_X);
              chars.push_back(($urandom_range(1) == 0) ? random_hex_char()
                                                       : random_plain_char());
              chars.push_back(random_plain_char());
            end
            default: begin
              chars.push_back(CH_BACKSLASH);
              chars.push_back(CH_BACKSLASH);
            end
          endcase
        end
        // cut some strings short so they end inside an escape
        if ($urandom_range(5) == 0 && chars.size() > 2) begin
          drop = $urandom_range(2, 1);
          for (int i = 0; i < drop; i++) void'(chars.pop_back());
        end
      end
      foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
      sent += chars.size();
    end
  endtask

  // test sequence
  initial begin
    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    in_idle_pct  = 9;
    out_idle_pct = 64;
    test_plain_chars();
    test_named_escapes();
    test_hex_escapes();
    test_open_escape_at_end();
    test_drain_pause();
    test_random_strings(PHASE_ITEMS);

    in_idle_pct  = 64;
    out_idle_pct = 9;
    test_random_strings(PHASE_ITEMS);

    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_strings(PHASE_ITEMS);

    idle_input();
    wait_for_bytes();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("tb_escape_sequence_decoder_unit: PASS");
    else
      $display("tb_escape_sequence_decoder_unit: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/esd_pkg.sv
design/esd_decode.sv
design/esd_out_stage.sv
design/escape_sequence_decoder_unit.sv
dv/tb_escape_sequence_decoder_unit.sv
